// ===== sv/lwrb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwrb_pkg
// Shared types and constants of the locked watchdog register block.
// ----------------------------------------------------------------------------
package lwrb_pkg;

   localparam int DEFAULT_SECONDS = 10;
   localparam int FRACTION_BITS   = 8;
   localparam int CNT_W           = 8 + FRACTION_BITS;

   localparam logic [CNT_W-1:0] DEFAULT_COUNT = CNT_W'(DEFAULT_SECONDS) << FRACTION_BITS;

   // Control register bit positions.
   localparam int BIT_EN0  = 0;
   localparam int BIT_EN1  = 1;
   localparam int BIT_LOCK = 2;
   localparam int BIT_OE0  = 6;
   localparam int BIT_OE1  = 7;

   localparam logic [7:0] KICK_BYTE = 8'h6b;

   typedef enum logic [2:0] {
      FUNC_READ  = 3'd0,
      FUNC_WRITE = 3'd1,
      FUNC_TICK  = 3'd2,
      FUNC_STOP  = 3'd3,
      FUNC_SOFT  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      REG_CONTROL = 2'd0,
      REG_TIMEOUT = 2'd1,
      REG_SERVICE = 2'd2,
      REG_COUNT   = 2'd3
   } reg_type;

   typedef enum logic {
      CSR_ENABLE_AT_RESET       = 1'b0,
      CSR_FAILSAFE_OFF_AT_RESET = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [2:0] func;
      logic [1:0] reg_offset;
      logic [7:0] write_byte;
      logic       force_reset;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       pin_driven;
      logic       pin_level;
      logic       reset_request;
      logic       reset_keeps_failsafe;
      logic       failsafe_release;
   } rsp_item_type;

   typedef struct packed {
      logic enable_at_reset;
      logic failsafe_off_at_reset;
   } cfg_type;

endpackage
`default_nettype wire

// ===== sv/lwrb_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwrb_core
// Watchdog state registers and the combinational update for one item.
// ----------------------------------------------------------------------------
module lwrb_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire lwrb_pkg::req_item_type item,
   input  wire lwrb_pkg::cfg_type      cfg,
   output lwrb_pkg::rsp_item_type      result
);
   import lwrb_pkg::*;

   logic [7:0]       control_ff, control_in;
   logic [CNT_W-1:0] reload_ff, reload_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             running_ff, running_in;
   logic             pin_on_ff, pin_on_in;
   logic             idle_high_ff, idle_high_in;

   logic [7:0] soft_control;
   logic       was_enabled;
   logic       edge_on;
   logic [7:0] rd;
   logic       req, keep, release_flag;

   always_comb begin
      soft_control = 8'h00;
      soft_control[BIT_OE0] = 1'b1;
      soft_control[BIT_EN0] = cfg.enable_at_reset;
      soft_control[BIT_EN1] = !cfg.failsafe_off_at_reset;
   end

   assign was_enabled = control_ff[BIT_EN0] | control_ff[BIT_EN1];
   assign edge_on = !was_enabled && (item.write_byte[BIT_EN0] | item.write_byte[BIT_EN1]);

   always_comb begin
      control_in   = control_ff;
      reload_in    = reload_ff;
      count_in     = count_ff;
      running_in   = running_ff;
      pin_on_in    = pin_on_ff;
      idle_high_in = idle_high_ff;
      rd           = 8'h00;
      req          = 1'b0;
      keep         = 1'b0;
      release_flag = 1'b0;
      unique case (item.func)
         FUNC_READ: begin
            unique case (item.reg_offset)
               REG_CONTROL: rd = control_ff;
               REG_TIMEOUT: rd = reload_ff[FRACTION_BITS +: 8];
               REG_COUNT:   rd = count_ff[FRACTION_BITS +: 8];
               default:     rd = 8'h00;
            endcase
         end
         FUNC_WRITE: begin
            unique case (item.reg_offset)
               REG_CONTROL: begin
                  if (!control_ff[BIT_LOCK]) begin
                     control_in   = item.write_byte;
                     running_in   = item.write_byte[BIT_EN0] | item.write_byte[BIT_EN1];
                     idle_high_in = !running_in;
                     pin_on_in    = item.write_byte[BIT_OE1];
                     release_flag = !item.write_byte[BIT_EN1];
                     if (edge_on) begin
                        count_in = reload_ff;
                     end
                  end
               end
               REG_TIMEOUT: reload_in = CNT_W'(item.write_byte) << FRACTION_BITS;
               REG_SERVICE: begin
                  if (item.write_byte == KICK_BYTE && running_ff) begin
                     count_in = reload_ff;
                  end
               end
               default: ;
            endcase
         end
         FUNC_TICK: begin
            if (running_ff) begin
               if (count_ff == '0) begin
                  running_in = 1'b0;
                  req        = control_ff[BIT_OE0];
                  keep       = control_ff[BIT_OE0] & control_ff[BIT_EN1];
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         FUNC_STOP: begin
            if (!control_ff[BIT_EN1]) begin
               running_in   = 1'b0;
               idle_high_in = 1'b1;
               pin_on_in    = 1'b0;
            end
         end
         FUNC_SOFT: begin
            if (item.force_reset || !control_ff[BIT_EN1]) begin
               control_in   = soft_control;
               reload_in    = DEFAULT_COUNT;
               count_in     = DEFAULT_COUNT;
               running_in   = soft_control[BIT_EN0] | soft_control[BIT_EN1];
               idle_high_in = !running_in;
               pin_on_in    = soft_control[BIT_OE1];
               release_flag = !soft_control[BIT_EN1];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= 8'h42;
         reload_ff    <= DEFAULT_COUNT;
         count_ff     <= DEFAULT_COUNT;
         running_ff   <= 1'b1;
         pin_on_ff    <= 1'b0;
         idle_high_ff <= 1'b0;
      end else if (accept) begin
         control_ff   <= control_in;
         reload_ff    <= reload_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         pin_on_ff    <= pin_on_in;
         idle_high_ff <= idle_high_in;
      end
   end

   // The status outputs report the state as it stands after this item.
   always_comb begin
      result.read_byte            = rd;
      result.pin_driven           = pin_on_in;
      result.pin_level            = running_in | idle_high_in;
      result.reset_request        = req;
      result.reset_keeps_failsafe = keep;
      result.failsafe_release     = release_flag;
   end

   a_expiry_stops: assert property (@(posedge clock) disable iff (reset)
      accept && item.func == FUNC_TICK && running_ff && count_ff == '0 |=> !running_ff)
      else $error("counter kept running after expiry");

   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      accept && item.func == FUNC_WRITE && item.reg_offset == REG_CONTROL
      && control_ff[BIT_LOCK] |=> $stable(control_ff))
      else $error("locked control register changed");

   a_kick_reloads: assert property (@(posedge clock) disable iff (reset)
      accept && item.func == FUNC_WRITE && item.reg_offset == REG_SERVICE
      && item.write_byte == KICK_BYTE && running_ff |=> count_ff == $past(reload_ff))
      else $error("kick did not reload the counter");

endmodule
`default_nettype wire

// ===== sv/locked_watchdog_register_block_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// locked_watchdog_register_block_unit
// Byte-register watchdog with magic kick, lock bit and failsafe mode.
// ----------------------------------------------------------------------------
// Every request beat is processed in the cycle it is accepted, so one beat
// per clock is sustained while rsp_tready is high; its response beat is held
// in a two-entry output register, which keeps req_tready high for one more
// beat while rsp_tready is low. Configuration writes are always ready and
// take effect at the next soft reset.
module locked_watchdog_register_block_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // func[2:0], reg_offset[4:3], write_byte[12:5], force_reset[13], zero[15:14]
   input  wire logic [15:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_byte[7:0], pin_driven[8], pin_level[9], reset_request[10],
   // reset_keeps_failsafe[11], failsafe_release[12], zero[15:13]
   output logic [15:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);
   import lwrb_pkg::*;

   cfg_type      cfg_ff;
   req_item_type item;
   rsp_item_type result;
   logic         accept, take;
   logic [15:0]  out_ff, skid_ff, result_word;
   logic         out_valid_ff, skid_valid_ff;
   logic         out_valid_in, skid_valid_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE_AT_RESET:       cfg_ff.enable_at_reset       <= csr_data[0];
            CSR_FAILSAFE_OFF_AT_RESET: cfg_ff.failsafe_off_at_reset <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign item.func        = req_tdata[2:0];
   assign item.reg_offset  = req_tdata[4:3];
   assign item.write_byte  = req_tdata[12:5];
   assign item.force_reset = req_tdata[13];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   lwrb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign result_word = {3'b000, result.failsafe_release, result.reset_keeps_failsafe,
                         result.reset_request, result.pin_level, result.pin_driven,
                         result.read_byte};

   // A beat still waiting in the output register sends the new one to the skid.
   assign out_valid_in  = (out_valid_ff && !take) || skid_valid_ff || accept;
   assign skid_valid_in = (skid_valid_ff || (accept && out_valid_ff)) && !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (accept && !(out_valid_ff && !take)) begin
         out_ff <= result_word;
      end
      if (accept && out_valid_ff && !take) begin
         skid_ff <= result_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule
`default_nettype wire
